// ===== hdl/lmhv_pkg.sv =====
// Shared types and constants for the lattice Merkle hash verifier.
package lmhv_pkg;

  localparam int unsigned DIM_N_DEF      = 4;
  localparam int unsigned DIGIT_BITS_DEF = 16;

  localparam int unsigned MAT_ROWS = 4;
  localparam int unsigned MAT_COLS = 64;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned COL_AW   = 6;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned VEC_W    = 64;
  localparam int unsigned KIND_W   = 2;

  localparam int unsigned MOD_W = 17;
  localparam logic [MOD_W-1:0] MOD_MIN   = 17'd2;
  localparam logic [MOD_W-1:0] MOD_MAX   = 17'd65536;
  localparam logic [MOD_W-1:0] MOD_RESET = 17'd65536;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ROOT = 1'b1;

  localparam int unsigned CMD_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_HASH  = 2'd1,
    OP_START = 2'd2,
    OP_STEP  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               matrix_sel;
    logic [ROW_W-1:0]   row;
    logic [COL_AW-1:0]  col;
    logic [COEF_W-1:0]  coef;
    logic [VEC_W-1:0]   first_vec;
    logic [VEC_W-1:0]   second_vec;
    logic               on_right;
    logic               last_step;
  } cmd_t;

  typedef struct packed {
    logic [VEC_W-1:0] digest;
    logic             is_member;
    logic             from_path;
  } res_t;

endpackage

// ===== hdl/lmhv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lmhv_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lmhv_front.sv =====
// Front end: accepts items, decodes the kind and queues commands for the back end.
module lmhv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [lmhv_pkg::KIND_W-1:0]   kind_i,
  input  logic                          matrix_sel_i,
  input  logic [lmhv_pkg::ROW_W-1:0]    row_index_i,
  input  logic [lmhv_pkg::COL_AW-1:0]   col_index_i,
  input  logic [lmhv_pkg::COEF_W-1:0]   coef_value_i,
  input  logic [lmhv_pkg::VEC_W-1:0]    first_vec_i,
  input  logic [lmhv_pkg::VEC_W-1:0]    second_vec_i,
  input  logic                          on_right_i,
  input  logic                          last_step_i,
  output logic                          cmd_valid_o,
  output lmhv_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  localparam int unsigned PTR_W = $clog2(lmhv_pkg::CMD_DEPTH);
  localparam int unsigned CNT_W = $clog2(lmhv_pkg::CMD_DEPTH + 1);

  lmhv_pkg::cmd_t    entry_q [lmhv_pkg::CMD_DEPTH];
  lmhv_pkg::cmd_t    cmd_in;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wr_en, rd_en;

  always_comb begin
    cmd_in            = '0;
    cmd_in.matrix_sel = matrix_sel_i;
    cmd_in.row        = row_index_i;
    cmd_in.col        = col_index_i;
    cmd_in.coef       = coef_value_i;
    cmd_in.first_vec  = first_vec_i;
    cmd_in.on_right   = on_right_i;
    cmd_in.last_step  = last_step_i;
    unique case (kind_i)
      lmhv_pkg::OP_LOAD:  cmd_in.op = lmhv_pkg::OP_LOAD;
      lmhv_pkg::OP_HASH: begin
        cmd_in.op         = lmhv_pkg::OP_HASH;
        cmd_in.second_vec = second_vec_i;
      end
      lmhv_pkg::OP_START: cmd_in.op = lmhv_pkg::OP_START;
      lmhv_pkg::OP_STEP:  cmd_in.op = lmhv_pkg::OP_STEP;
      default:            cmd_in.op = lmhv_pkg::OP_LOAD;
    endcase
  end

  assign full        = (cnt_q == CNT_W'(lmhv_pkg::CMD_DEPTH));
  assign wr_en       = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hdl/lmhv_back.sv =====
// Back end: matrix storage, column sweep, bit-serial reduction, path node and result register.
module lmhv_back #(
  parameter int unsigned DIM_N      = lmhv_pkg::DIM_N_DEF,
  parameter int unsigned DIGIT_BITS = lmhv_pkg::DIGIT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  lmhv_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  input  logic [lmhv_pkg::MOD_W-1:0]    modulus_i,
  input  logic [lmhv_pkg::VEC_W-1:0]    expected_root_i,
  output logic                          res_valid_o,
  output lmhv_pkg::res_t                res_o,
  input  logic                          res_pop_i
);

  localparam int unsigned NCOLS = (DIM_N * DIGIT_BITS > lmhv_pkg::VEC_W) ?
                                  lmhv_pkg::VEC_W : DIM_N * DIGIT_BITS;
  localparam int unsigned ROWS  = (DIM_N < lmhv_pkg::MAT_ROWS) ? DIM_N : lmhv_pkg::MAT_ROWS;
  localparam int unsigned SUM_W = lmhv_pkg::COEF_W + $clog2(2 * NCOLS);
  localparam int unsigned COL_W = $clog2(NCOLS + 1);
  localparam int unsigned RED_W = $clog2(SUM_W);
  localparam int unsigned REM_W = lmhv_pkg::COEF_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCUM  = 4'b0010,
    S_REDUCE = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [lmhv_pkg::VEC_W-1:0]    x_q, x_d, y_q, y_d, node_q, node_d;
  logic [COL_W-1:0]              col_q, col_d;
  logic [RED_W-1:0]              red_q, red_d;
  logic                          rd_vld_q, rd_vld_d, xb_q, xb_d, yb_q, yb_d;
  logic                          emit_q, emit_d, path_q, path_d;
  logic [SUM_W-1:0]              sum_q [ROWS];
  logic [SUM_W-1:0]              sum_d [ROWS];
  logic [REM_W-1:0]              rem_q [ROWS];
  logic [REM_W-1:0]              rem_d [ROWS];
  logic [lmhv_pkg::COEF_W-1:0]   l_rd [ROWS];
  logic [lmhv_pkg::COEF_W-1:0]   r_rd [ROWS];
  logic [REM_W:0]                shifted [ROWS];
  logic [lmhv_pkg::VEC_W-1:0]    digest;
  logic                          issue, is_load, res_ready, finish;
  logic [lmhv_pkg::COL_AW-1:0]   raddr;
  lmhv_pkg::res_t                out_q, out_d;
  logic                          out_full_q, out_full_d;

  assign is_load = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == lmhv_pkg::OP_LOAD);
  assign issue   = (state_q == S_ACCUM) && (col_q < COL_W'(NCOLS));
  assign raddr   = lmhv_pkg::COL_AW'(col_q);

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    lmhv_ram #(
      .WIDTH (lmhv_pkg::COEF_W),
      .DEPTH (lmhv_pkg::MAT_COLS)
    ) u_left_ram (
      .clk_i   (clk_i),
      .we_i    (is_load && !cmd_i.matrix_sel && (cmd_i.row == lmhv_pkg::ROW_W'(r))),
      .waddr_i (cmd_i.col),
      .wdata_i (cmd_i.coef),
      .raddr_i (raddr),
      .rdata_o (l_rd[r])
    );
    lmhv_ram #(
      .WIDTH (lmhv_pkg::COEF_W),
      .DEPTH (lmhv_pkg::MAT_COLS)
    ) u_right_ram (
      .clk_i   (clk_i),
      .we_i    (is_load && cmd_i.matrix_sel && (cmd_i.row == lmhv_pkg::ROW_W'(r))),
      .waddr_i (cmd_i.col),
      .wdata_i (cmd_i.coef),
      .raddr_i (raddr),
      .rdata_o (r_rd[r])
    );
  end

  always_comb begin
    digest = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int t = 0; t < DIGIT_BITS; t++) begin
        if (r * DIGIT_BITS + t < lmhv_pkg::VEC_W) begin
          digest[r * DIGIT_BITS + t] = rem_q[r][DIGIT_BITS - 1 - t];
        end
      end
    end
  end

  assign res_ready = !out_full_q || res_pop_i;
  assign finish    = (state_q == S_DONE) && (!emit_q || res_ready);

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    node_d    = node_q;
    col_d     = col_q;
    red_d     = red_q;
    emit_d    = emit_q;
    path_d    = path_q;
    cmd_pop_o = 1'b0;
    rd_vld_d  = issue;
    xb_d      = x_q[0];
    yb_d      = y_q[0];
    for (int r = 0; r < ROWS; r++) begin
      sum_d[r]   = sum_q[r];
      rem_d[r]   = rem_q[r];
      shifted[r] = {rem_q[r], sum_q[r][SUM_W-1]};
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            lmhv_pkg::OP_LOAD: ;
            lmhv_pkg::OP_START: node_d = cmd_i.first_vec;
            lmhv_pkg::OP_HASH: begin
              x_d     = cmd_i.first_vec;
              y_d     = cmd_i.second_vec;
              emit_d  = 1'b1;
              path_d  = 1'b0;
              state_d = S_ACCUM;
            end
            lmhv_pkg::OP_STEP: begin
              x_d     = cmd_i.on_right ? cmd_i.first_vec : node_q;
              y_d     = cmd_i.on_right ? node_q : cmd_i.first_vec;
              emit_d  = cmd_i.last_step;
              path_d  = 1'b1;
              state_d = S_ACCUM;
            end
            default: ;
          endcase
          col_d = '0;
          for (int r = 0; r < ROWS; r++) begin
            sum_d[r] = '0;
            rem_d[r] = '0;
          end
        end
      end
      S_ACCUM: begin
        if (issue) begin
          col_d = col_q + 1'b1;
          x_d   = x_q >> 1;
          y_d   = y_q >> 1;
        end
        if (rd_vld_q) begin
          for (int r = 0; r < ROWS; r++) begin
            sum_d[r] = sum_q[r] + SUM_W'(xb_q ? l_rd[r] : '0) + SUM_W'(yb_q ? r_rd[r] : '0);
          end
        end
        if (!issue) begin
          red_d   = RED_W'(SUM_W - 1);
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        for (int r = 0; r < ROWS; r++) begin
          sum_d[r] = sum_q[r] << 1;
          rem_d[r] = (shifted[r] >= modulus_i) ? REM_W'(shifted[r] - modulus_i)
                                               : REM_W'(shifted[r]);
        end
        red_d = red_q - 1'b1;
        if (red_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          if (path_q) begin
            node_d = digest;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d      = out_q;
    out_full_d = out_full_q;
    if (res_pop_i && out_full_q) begin
      out_full_d = 1'b0;
    end
    if (finish && emit_q) begin
      out_full_d      = 1'b1;
      out_d.digest    = digest;
      out_d.from_path = path_q;
      out_d.is_member = path_q && (digest == expected_root_i);
    end
  end

  assign res_valid_o = out_full_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      node_q     <= '0;
      rd_vld_q   <= 1'b0;
      emit_q     <= 1'b0;
      path_q     <= 1'b0;
      col_q      <= '0;
      red_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      node_q     <= node_d;
      rd_vld_q   <= rd_vld_d;
      emit_q     <= emit_d;
      path_q     <= path_d;
      col_q      <= col_d;
      red_q      <= red_d;
      out_full_q <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    xb_q  <= xb_d;
    yb_q  <= yb_d;
    out_q <= out_d;
    for (int r = 0; r < ROWS; r++) begin
      sum_q[r] <= sum_d[r];
      rem_q[r] <= rem_d[r];
    end
  end

endmodule

// ===== hdl/lattice_merkle_hash_verify_top.sv =====
// Top level of the lattice Merkle hash verifier: config registers, front end and back end.
// Load and start beats hold the back end for 1 cycle; a hash pair or any path step holds
// it through a column sweep of the matrix RAMs, a bit-serial reduction that makes one
// remainder bit per cycle, and a done state that waits for room in the result register.
// The back end takes no new beat until it is through with the last one, and a 2-beat
// command queue buffers the input side.
// Reset clears the queues, the path node, modulus (65536) and expected root (zero);
// matrix RAM contents stay undefined until loaded.
module lattice_merkle_hash_verify_top #(
  parameter int unsigned DIM_N      = lmhv_pkg::DIM_N_DEF,
  parameter int unsigned DIGIT_BITS = lmhv_pkg::DIGIT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmhv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lmhv_pkg::VEC_W-1:0]      cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [lmhv_pkg::KIND_W-1:0]     kind_i,
  input  logic                            matrix_sel_i,
  input  logic [lmhv_pkg::ROW_W-1:0]      row_index_i,
  input  logic [lmhv_pkg::COL_AW-1:0]     col_index_i,
  input  logic [lmhv_pkg::COEF_W-1:0]     coef_value_i,
  input  logic [lmhv_pkg::VEC_W-1:0]      first_vec_i,
  input  logic [lmhv_pkg::VEC_W-1:0]      second_vec_i,
  input  logic                            on_right_i,
  input  logic                            last_step_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [lmhv_pkg::VEC_W-1:0]      digest_o,
  output logic                            is_member_o,
  output logic                            from_path_o
);

  logic [lmhv_pkg::MOD_W-1:0]  modulus_q, modulus_d, cfg_mod;
  logic [lmhv_pkg::VEC_W-1:0]  root_q, root_d;
  logic                        cmd_valid, cmd_pop, res_valid;
  lmhv_pkg::cmd_t              cmd;
  lmhv_pkg::res_t              res;

  assign cfg_mod = cfg_data_i[lmhv_pkg::MOD_W-1:0];

  always_comb begin
    modulus_d = modulus_q;
    root_d    = root_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lmhv_pkg::REG_MODULUS: begin
          if (cfg_mod < lmhv_pkg::MOD_MIN) begin
            modulus_d = lmhv_pkg::MOD_MIN;
          end else if (cfg_mod > lmhv_pkg::MOD_MAX) begin
            modulus_d = lmhv_pkg::MOD_MAX;
          end else begin
            modulus_d = cfg_mod;
          end
        end
        lmhv_pkg::REG_EXPECTED_ROOT: root_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= lmhv_pkg::MOD_RESET;
      root_q    <= '0;
    end else begin
      modulus_q <= modulus_d;
      root_q    <= root_d;
    end
  end

  lmhv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .matrix_sel_i (matrix_sel_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .coef_value_i (coef_value_i),
    .first_vec_i  (first_vec_i),
    .second_vec_i (second_vec_i),
    .on_right_i   (on_right_i),
    .last_step_i  (last_step_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  lmhv_back #(
    .DIM_N      (DIM_N),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .modulus_i       (modulus_q),
    .expected_root_i (root_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_pop_i       (pop)
  );

  assign empty       = !res_valid;
  assign digest_o    = res.digest;
  assign is_member_o = res.is_member;
  assign from_path_o = res.from_path;

endmodule

// ===== hdl/lmhv_checker.sv =====
// Port-level checker for the lattice Merkle hash verifier and its bind.
module lmhv_checker #(
  parameter int unsigned DIM_N      = lmhv_pkg::DIM_N_DEF,
  parameter int unsigned DIGIT_BITS = lmhv_pkg::DIGIT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic                        full,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [lmhv_pkg::VEC_W-1:0]  digest_o,
  input  logic                        is_member_o,
  input  logic                        from_path_o
);

  localparam int unsigned NCOLS = (DIM_N * DIGIT_BITS > lmhv_pkg::VEC_W) ?
                                  lmhv_pkg::VEC_W : DIM_N * DIGIT_BITS;

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digest_o) && $stable(from_path_o)))
    else $error("waiting beat changed before pop");

  a_member_from_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_member_o) |-> from_path_o)
    else $error("membership flagged on a hash pair beat");

  a_digest_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((digest_o >> NCOLS) == '0))
    else $error("digest bits set above the vector length");

  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("input side filled with no beat pushed");

endmodule

bind lattice_merkle_hash_verify_top lmhv_checker #(
  .DIM_N      (DIM_N),
  .DIGIT_BITS (DIGIT_BITS)
) u_lmhv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .digest_o    (digest_o),
  .is_member_o (is_member_o),
  .from_path_o (from_path_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the lattice Merkle hash verifier: queued stimulus, scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM_N      = lmhv_pkg::DIM_N_DEF;
  localparam int unsigned DIGIT_BITS = lmhv_pkg::DIGIT_BITS_DEF;
  localparam int unsigned NCOLS      = (DIM_N * DIGIT_BITS > 64) ? 64 : DIM_N * DIGIT_BITS;
  localparam int unsigned SETTLE_CYCLES = 1000;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned QUIET_LIMIT   = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we = 1'b0;
  logic [lmhv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lmhv_pkg::VEC_W-1:0]     cfg_data = '0;

  logic                         push = 1'b0;
  logic                         full;
  logic [lmhv_pkg::KIND_W-1:0]  kind = '0;
  logic                         matrix_sel = 1'b0;
  logic [lmhv_pkg::ROW_W-1:0]   row_index = '0;
  logic [lmhv_pkg::COL_AW-1:0]  col_index = '0;
  logic [lmhv_pkg::COEF_W-1:0]  coef_value = '0;
  logic [lmhv_pkg::VEC_W-1:0]   first_vec = '0;
  logic [lmhv_pkg::VEC_W-1:0]   second_vec = '0;
  logic                         on_right = 1'b0;
  logic                         last_step = 1'b0;

  logic                         empty;
  logic                         pop = 1'b0;
  logic [lmhv_pkg::VEC_W-1:0]   digest;
  logic                         is_member;
  logic                         from_path;

  lattice_merkle_hash_verify_top #(
    .DIM_N(DIM_N),
    .DIGIT_BITS(DIGIT_BITS)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .push(push),
    .full(full),
    .kind_i(kind),
    .matrix_sel_i(matrix_sel),
    .row_index_i(row_index),
    .col_index_i(col_index),
    .coef_value_i(coef_value),
    .first_vec_i(first_vec),
    .second_vec_i(second_vec),
    .on_right_i(on_right),
    .last_step_i(last_step),
    .empty(empty),
    .pop(pop),
    .digest_o(digest),
    .is_member_o(is_member),
    .from_path_o(from_path)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the block
  logic [lmhv_pkg::COEF_W-1:0] left_coef [lmhv_pkg::MAT_ROWS*lmhv_pkg::MAT_COLS];
  logic [lmhv_pkg::COEF_W-1:0] right_coef [lmhv_pkg::MAT_ROWS*lmhv_pkg::MAT_COLS];
  logic [lmhv_pkg::VEC_W-1:0]  path_node_q = '0;
  logic [lmhv_pkg::MOD_W-1:0]  q_reg = lmhv_pkg::MOD_RESET;
  logic [lmhv_pkg::VEC_W-1:0]  root_reg = '0;

  lmhv_pkg::cmd_t cmd_backlog [$];
  lmhv_pkg::cmd_t path_stage [$];
  lmhv_pkg::res_t digest_due [$];

  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  logic [7:0]  stall_pat = 8'hFF;
  logic [4:0]  pat_step = '0;

  function automatic logic [lmhv_pkg::VEC_W-1:0] sis_digest(logic [lmhv_pkg::VEC_W-1:0] x,
                                                            logic [lmhv_pkg::VEC_W-1:0] y);
    logic [lmhv_pkg::VEC_W-1:0] out_v;
    longint unsigned sum;
    longint unsigned q;
    longint unsigned r;
    int unsigned base;
    int unsigned pos;
    out_v = '0;
    q = (q_reg < lmhv_pkg::MOD_MIN) ? lmhv_pkg::MOD_MIN :
        (q_reg > lmhv_pkg::MOD_MAX) ? lmhv_pkg::MOD_MAX : q_reg;
    for (int i = 0; i < DIM_N; i++) begin
      base = i * DIGIT_BITS;
      if (base < NCOLS) begin
        sum = 0;
        if (i < lmhv_pkg::MAT_ROWS) begin
          for (int c = 0; c < NCOLS; c++) begin
            if (x[c]) sum += left_coef[i*lmhv_pkg::MAT_COLS + c];
            if (y[c]) sum += right_coef[i*lmhv_pkg::MAT_COLS + c];
          end
        end
        r = sum % q;
        for (int t = 0; t < DIGIT_BITS; t++) begin
          pos = base + t;
          if (pos < NCOLS && r[DIGIT_BITS-1-t]) out_v[pos] = 1'b1;
        end
      end
    end
    return out_v;
  endfunction

  task automatic absorb_cmd(lmhv_pkg::cmd_t c);
    lmhv_pkg::res_t r;
    case (c.op)
      lmhv_pkg::OP_LOAD: begin
        if (c.matrix_sel) right_coef[{c.row, c.col}] = c.coef;
        else left_coef[{c.row, c.col}] = c.coef;
      end
      lmhv_pkg::OP_HASH: begin
        r.digest = sis_digest(c.first_vec, c.second_vec);
        r.is_member = 1'b0;
        r.from_path = 1'b0;
        digest_due.push_back(r);
      end
      lmhv_pkg::OP_START: path_node_q = c.first_vec;
      default: begin
        path_node_q = c.on_right ? sis_digest(c.first_vec, path_node_q)
                                 : sis_digest(path_node_q, c.first_vec);
        if (c.last_step) begin
          r.digest = path_node_q;
          r.is_member = (path_node_q == root_reg);
          r.from_path = 1'b1;
          digest_due.push_back(r);
        end
      end
    endcase
  endtask

  function automatic logic [lmhv_pkg::VEC_W-1:0] rand_vec();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic lmhv_pkg::cmd_t rand_cmd(lmhv_pkg::op_e op);
    lmhv_pkg::cmd_t c;
    c.op = op;
    c.matrix_sel = 1'($urandom_range(0, 1));
    c.row = lmhv_pkg::ROW_W'($urandom_range(0, 3));
    c.col = lmhv_pkg::COL_AW'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: c.coef = '0;
      1: c.coef = '1;
      default: c.coef = lmhv_pkg::COEF_W'($urandom);
    endcase
    c.first_vec = rand_vec();
    c.second_vec = rand_vec();
    c.on_right = 1'($urandom_range(0, 1));
    c.last_step = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Stage a start plus n_mid+1 steps; return the root seen from the current state.
  function automatic logic [lmhv_pkg::VEC_W-1:0] build_path(int unsigned n_mid);
    lmhv_pkg::cmd_t c;
    logic [lmhv_pkg::VEC_W-1:0] node;
    path_stage.delete();
    c = rand_cmd(lmhv_pkg::OP_START);
    node = c.first_vec;
    path_stage.push_back(c);
    for (int k = 0; k <= n_mid; k++) begin
      c = rand_cmd(lmhv_pkg::OP_STEP);
      c.last_step = (k == n_mid);
      node = c.on_right ? sis_digest(c.first_vec, node) : sis_digest(node, c.first_vec);
      path_stage.push_back(c);
    end
    return node;
  endfunction

  task automatic commit_path();
    foreach (path_stage[k]) cmd_backlog.push_back(path_stage[k]);
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned made;
    int unsigned steps;
    int unsigned pick;
    logic [lmhv_pkg::VEC_W-1:0] unused_root;
    lmhv_pkg::cmd_t c;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        steps = $urandom_range(0, 4);
        unused_root = build_path(steps);
        commit_path();
        made += steps + 2;
      end else begin
        if (pick < 70) c = rand_cmd(lmhv_pkg::OP_HASH);
        else if (pick < 85) c = rand_cmd(lmhv_pkg::OP_LOAD);
        else if (pick < 93) c = rand_cmd(lmhv_pkg::OP_STEP);
        else c = rand_cmd(lmhv_pkg::OP_START);
        cmd_backlog.push_back(c);
        made++;
      end
    end
  endtask

  task automatic write_reg(logic [lmhv_pkg::CFG_IDX_W-1:0] idx,
                           logic [lmhv_pkg::VEC_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == lmhv_pkg::REG_MODULUS) q_reg = data[lmhv_pkg::MOD_W-1:0];
    else root_reg = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || push || digest_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, logic [lmhv_pkg::VEC_W-1:0] got,
                               logic [lmhv_pkg::VEC_W-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_beat();
    lmhv_pkg::res_t want;
    if (digest_due.size() == 0) begin
      flag_mismatch("result beat with nothing expected", digest, '0);
    end else begin
      want = digest_due.pop_front();
      if (digest !== want.digest) flag_mismatch("digest", digest, want.digest);
      if (is_member !== want.is_member) flag_mismatch("is_member", 64'(is_member),
                                                      64'(want.is_member));
      if (from_path !== want.from_path) flag_mismatch("from_path", 64'(from_path),
                                                      64'(want.from_path));
    end
  endtask

  // Sender: bursts from the backlog with random gaps
  always @(posedge clk) begin
    logic take_next;
    lmhv_pkg::cmd_t c;
    if (rst_n) begin
      take_next = 1'b0;
      if (push && !full) begin
        absorb_cmd(cmd_backlog.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 24);
        end
        take_next = (gap_left == 0);
      end else if (!push) begin
        if (gap_left > 0) gap_left--;
        take_next = (gap_left == 0);
      end
      if (!(push && full)) begin
        if (take_next && cmd_backlog.size() != 0) begin
          c = cmd_backlog[0];
          push <= 1'b1;
          kind <= c.op;
          matrix_sel <= c.matrix_sel;
          row_index <= c.row;
          col_index <= c.col;
          coef_value <= c.coef;
          first_vec <= c.first_vec;
          second_vec <= c.second_vec;
          on_right <= c.on_right;
          last_step <= c.last_step;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check beats, stall on a rotating pattern, long hold on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) check_beat();
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      pat_step++;
      if (pat_step == 0) stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      pop <= (hold_left == 0) && stall_pat[pat_step[2:0]];
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    lmhv_pkg::cmd_t c;
    logic [lmhv_pkg::VEC_W-1:0] root;
    logic [lmhv_pkg::VEC_W-1:0] q_plan [10];
    q_plan[0] = 64'd2;
    q_plan[1] = 64'd0;
    q_plan[2] = 64'd1;
    q_plan[3] = 64'hFFFF_FFFF_0001_FFFF;
    q_plan[4] = 64'd65537;
    q_plan[5] = 64'd3;
    q_plan[6] = 64'd257;
    q_plan[7] = 64'($urandom_range(4, 65534));
    q_plan[8] = 64'd65535;
    q_plan[9] = 64'd65536;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(lmhv_pkg::REG_MODULUS, 64'd65536);
    write_reg(lmhv_pkg::REG_EXPECTED_ROOT, 64'd0);

    // Load every matrix entry; left row 0 at full scale
    for (int s = 0; s < 2; s++) begin
      for (int a = 0; a < lmhv_pkg::MAT_ROWS * lmhv_pkg::MAT_COLS; a++) begin
        c = rand_cmd(lmhv_pkg::OP_LOAD);
        c.matrix_sel = 1'(s);
        {c.row, c.col} = 8'(a);
        if (s == 0 && a < lmhv_pkg::MAT_COLS) c.coef = '1;
        cmd_backlog.push_back(c);
      end
    end

    // Step with no start: works from the reset path node
    c = rand_cmd(lmhv_pkg::OP_STEP);
    c.on_right = 1'b0;
    c.last_step = 1'b1;
    cmd_backlog.push_back(c);
    for (int k = 0; k < 4; k++) begin
      c = rand_cmd(lmhv_pkg::OP_HASH);
      c.first_vec = k[0] ? '1 : '0;
      c.second_vec = k[1] ? '1 : '0;
      cmd_backlog.push_back(c);
    end
    // Zero leaf and sibling give a zero root, matching the reset root
    c = rand_cmd(lmhv_pkg::OP_START);
    c.first_vec = '0;
    cmd_backlog.push_back(c);
    c = rand_cmd(lmhv_pkg::OP_STEP);
    c.first_vec = '0;
    c.last_step = 1'b1;
    cmd_backlog.push_back(c);
    cmd_backlog.push_back(rand_cmd(lmhv_pkg::OP_START));
    for (int k = 0; k < 3; k++) begin
      c = rand_cmd(lmhv_pkg::OP_STEP);
      c.on_right = ~k[0];
      c.last_step = (k == 2);
      cmd_backlog.push_back(c);
    end
    c = rand_cmd(lmhv_pkg::OP_LOAD);
    c.matrix_sel = 1'b0;
    c.row = 2'd3;
    c.col = 6'd63;
    c.coef = '1;
    cmd_backlog.push_back(c);
    c = rand_cmd(lmhv_pkg::OP_LOAD);
    c.matrix_sel = 1'b1;
    c.row = 2'd0;
    c.col = 6'd0;
    c.coef = '0;
    cmd_backlog.push_back(c);
    c = rand_cmd(lmhv_pkg::OP_HASH);
    c.first_vec = '1;
    c.second_vec = '1;
    cmd_backlog.push_back(c);
    settle();

    for (int p = 0; p < 10; p++) begin
      write_reg(lmhv_pkg::REG_MODULUS, q_plan[p]);
      case (p % 4)
        0: begin
          root = build_path($urandom_range(0, 4));
          write_reg(lmhv_pkg::REG_EXPECTED_ROOT, root);
          commit_path();
        end
        1: write_reg(lmhv_pkg::REG_EXPECTED_ROOT, {$urandom, $urandom});
        2: begin
          root = build_path($urandom_range(0, 4));
          write_reg(lmhv_pkg::REG_EXPECTED_ROOT, root ^ (64'd1 << $urandom_range(0, 63)));
          commit_path();
        end
        default: write_reg(lmhv_pkg::REG_EXPECTED_ROOT, p[2] ? '1 : '0);
      endcase
      if (p == 3 || p == 7) begin
        hold_req <= ~hold_req;
        for (int k = 0; k < 10; k++) cmd_backlog.push_back(rand_cmd(lmhv_pkg::OP_HASH));
      end
      fill_random(6);
      settle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lmhv_pkg.sv
hdl/lmhv_ram.sv
hdl/lmhv_front.sv
hdl/lmhv_back.sv
hdl/lattice_merkle_hash_verify_top.sv
hdl/lmhv_checker.sv
tb/tb_top.sv
